### hdl/dht_pkg.sv
// Shared types, constants and key tables for the two-set keyboard transcoder.
// Used by every module of the block; depends on nothing else.
package dht_pkg;

    localparam int LOOKAHEAD_DEPTH_DEF = 6;
    localparam int NEED = 6;
    localparam int Q_DEPTH = 4;

    localparam logic [15:0] SYL_BASE      = 16'hAC00;
    localparam logic [15:0] VOW_BASE      = 16'h314F;
    localparam logic [15:0] CON_BASE      = 16'h3131;
    localparam logic [15:0] SYL_INIT_STEP = 16'd588;
    localparam logic [15:0] SYL_VOW_STEP  = 16'd28;

    // Marks a table miss in the 5-bit indices that the key lookups return.
    localparam logic [4:0] NO_IDX = 5'd31;

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  key;
        logic        eot;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_wr_t;

    // ASCII letter or zero for everything else.
    function automatic logic [7:0] key_of(logic [15:0] c);
        logic [7:0] b;
        b = c[7:0];
        if (c[15:8] == 8'h00 && ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")))
            return b;
        return 8'h00;
    endfunction

    function automatic logic [7:0] low_of(logic [7:0] k);
        return k | 8'h20;
    endfunction

    function automatic logic [4:0] initial_of(logic [7:0] k);
        logic [4:0] r;
        unique case (k)
            "r": r = 5'd0;
            "R": r = 5'd1;
            "s", "S": r = 5'd2;
            "e": r = 5'd3;
            "E": r = 5'd4;
            "f", "F": r = 5'd5;
            "a", "A": r = 5'd6;
            "q": r = 5'd7;
            "Q": r = 5'd8;
            "t": r = 5'd9;
            "T": r = 5'd10;
            "d", "D": r = 5'd11;
            "w": r = 5'd12;
            "W": r = 5'd13;
            "c", "C": r = 5'd14;
            "z", "Z": r = 5'd15;
            "x", "X": r = 5'd16;
            "v", "V": r = 5'd17;
            "g", "G": r = 5'd18;
            default: r = NO_IDX;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] vowel_one(logic [7:0] k);
        logic [4:0] r;
        unique case (k)
            "k", "K": r = 5'd0;
            "o": r = 5'd1;
            "i", "I": r = 5'd2;
            "O": r = 5'd3;
            "j", "J": r = 5'd4;
            "p": r = 5'd5;
            "u", "U": r = 5'd6;
            "P": r = 5'd7;
            "h", "H": r = 5'd8;
            "y", "Y": r = 5'd12;
            "n", "N": r = 5'd13;
            "b", "B": r = 5'd17;
            "m", "M": r = 5'd18;
            "l", "L": r = 5'd20;
            default: r = NO_IDX;
        endcase
        return r;
    endfunction

    function automatic logic is_vowel(logic [7:0] k);
        return vowel_one(k) != NO_IDX;
    endfunction

    function automatic logic [4:0] vowel_two(logic [7:0] a, logic [7:0] b);
        logic [7:0] la;
        logic [7:0] lb;
        logic [4:0] r;
        la = low_of(a);
        lb = low_of(b);
        r = NO_IDX;
        if (la == "h") begin
            if (lb == "k")
                r = 5'd9;
            else if (b == "o")
                r = 5'd10;
            else if (lb == "l")
                r = 5'd11;
        end else if (la == "n") begin
            if (lb == "j")
                r = 5'd14;
            else if (b == "p")
                r = 5'd15;
            else if (lb == "l")
                r = 5'd16;
        end else if (la == "m") begin
            if (lb == "l")
                r = 5'd19;
        end
        return r;
    endfunction

    function automatic logic [4:0] final_one(logic [7:0] k);
        logic [4:0] r;
        unique case (k)
            "r": r = 5'd1;
            "R": r = 5'd2;
            "s", "S": r = 5'd4;
            "e": r = 5'd7;
            "f", "F": r = 5'd8;
            "a", "A": r = 5'd16;
            "q": r = 5'd17;
            "t": r = 5'd19;
            "T": r = 5'd20;
            "d", "D": r = 5'd21;
            "w": r = 5'd22;
            "c", "C": r = 5'd23;
            "z", "Z": r = 5'd24;
            "x", "X": r = 5'd25;
            "v", "V": r = 5'd26;
            "g", "G": r = 5'd27;
            default: r = NO_IDX;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] single_one(logic [7:0] k);
        logic [4:0] r;
        unique case (k)
            "r": r = 5'd0;
            "R": r = 5'd1;
            "s", "S": r = 5'd3;
            "e": r = 5'd6;
            "E": r = 5'd7;
            "f", "F": r = 5'd8;
            "a", "A": r = 5'd16;
            "q": r = 5'd17;
            "Q": r = 5'd18;
            "t": r = 5'd20;
            "T": r = 5'd21;
            "d", "D": r = 5'd22;
            "w": r = 5'd23;
            "W": r = 5'd24;
            "c", "C": r = 5'd25;
            "z", "Z": r = 5'd26;
            "x", "X": r = 5'd27;
            "v", "V": r = 5'd28;
            "g", "G": r = 5'd29;
            default: r = NO_IDX;
        endcase
        return r;
    endfunction

    // Two-key consonant cluster number 0 to 10.
    function automatic logic [4:0] cluster_of(logic [7:0] a, logic [7:0] b);
        logic [7:0] la;
        logic [7:0] lb;
        logic [4:0] r;
        la = low_of(a);
        lb = low_of(b);
        r = NO_IDX;
        if (a == "r" && b == "t")
            r = 5'd0;
        else if (la == "s" && b == "w")
            r = 5'd1;
        else if (la == "s" && lb == "g")
            r = 5'd2;
        else if (la == "f" && b == "r")
            r = 5'd3;
        else if (la == "f" && lb == "a")
            r = 5'd4;
        else if (la == "f" && b == "q")
            r = 5'd5;
        else if (la == "f" && b == "t")
            r = 5'd6;
        else if (la == "f" && lb == "x")
            r = 5'd7;
        else if (la == "f" && lb == "v")
            r = 5'd8;
        else if (la == "f" && lb == "g")
            r = 5'd9;
        else if (a == "q" && b == "t")
            r = 5'd10;
        return r;
    endfunction

    function automatic logic [4:0] final_of_cluster(logic [4:0] x);
        logic [4:0] r;
        unique case (x)
            5'd0: r = 5'd3;
            5'd1: r = 5'd5;
            5'd2: r = 5'd6;
            5'd3: r = 5'd9;
            5'd4: r = 5'd10;
            5'd5: r = 5'd11;
            5'd6: r = 5'd12;
            5'd7: r = 5'd13;
            5'd8: r = 5'd14;
            5'd9: r = 5'd15;
            5'd10: r = 5'd18;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] jamo_of_cluster(logic [4:0] x);
        logic [4:0] r;
        unique case (x)
            5'd0: r = 5'd2;
            5'd1: r = 5'd4;
            5'd2: r = 5'd5;
            5'd3: r = 5'd9;
            5'd4: r = 5'd10;
            5'd5: r = 5'd11;
            5'd6: r = 5'd12;
            5'd7: r = 5'd13;
            5'd8: r = 5'd14;
            5'd9: r = 5'd15;
            5'd10: r = 5'd19;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/dht_front.sv
// Input side: accepts typed characters and classifies each into a letter key.
// Depends on dht_pkg.
module dht_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // char_code
    input  logic              s_axis_tlast,   // end_of_text
    input  logic              q_full,
    output dht_pkg::q_wr_t    q_wr
);

    // Ready stays low while a register cleared by reset is still unset, and then follows the room
    // left in the queue; classification itself is purely combinational.
    logic ready_reg;
    logic has_room;

    assign has_room = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_reg <= 1'b0;
        else
            ready_reg <= 1'b1;
    end

    assign s_axis_tready  = ready_reg && has_room;
    assign q_wr.push      = s_axis_tvalid && s_axis_tready;
    assign q_wr.item.code = s_axis_tdata;
    assign q_wr.item.key  = dht_pkg::key_of(s_axis_tdata);
    assign q_wr.item.eot  = s_axis_tlast;

endmodule

### hdl/dht_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Depends on dht_pkg.
module dht_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  dht_pkg::q_wr_t    q_wr,
    output logic              q_full,
    output logic              q_valid,
    output dht_pkg::item_t    q_item,
    input  logic              q_pop
);

    localparam int AW = $clog2(dht_pkg::Q_DEPTH);
    localparam int CW = $clog2(dht_pkg::Q_DEPTH + 1);

    dht_pkg::item_t   slot_reg [dht_pkg::Q_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             do_pop;

    assign q_full  = cnt_reg == CW'(dht_pkg::Q_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_wr.push)
            wr_ptr_next = (wr_ptr_reg == AW'(dht_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(dht_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (q_wr.push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!q_wr.push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            slot_reg[wr_ptr_reg] <= q_wr.item;
    end

endmodule

### hdl/dht_back.sv
// Back end: lookahead window, syllable decision and the output register.
// Depends on dht_pkg.
module dht_back
#(
    parameter int LOOKAHEAD_DEPTH = dht_pkg::LOOKAHEAD_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  dht_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // out_code
    output logic              m_axis_tlast    // out_last
);

    localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IW = $clog2(LOOKAHEAD_DEPTH);
    localparam int SW = CW + 1;

    logic [15:0]    code_reg [LOOKAHEAD_DEPTH];
    logic [7:0]     key_reg  [LOOKAHEAD_DEPTH];
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           flush_reg;
    logic           flush_next;
    logic           ovalid_reg;
    logic           ovalid_next;
    logic [15:0]    ocode_reg;
    logic           olast_reg;

    logic [7:0]     k [dht_pkg::NEED];
    logic           need_dec;
    logic           dec_go;
    logic [15:0]    dec_code;
    logic [2:0]     dec_used;
    logic [CW-1:0]  used_c;

    always_comb
    begin
        for (int i = 0; i < dht_pkg::NEED; i++)
            k[i] = (CW'(i) < cnt_reg) ? key_reg[IW'(i)] : 8'h00;
    end

    // One decision at the window front.
    always_comb
    begin
        logic [4:0] fi;
        logic [4:0] v;
        logic [4:0] v2;
        logic [4:0] v1;
        logic [4:0] idx;
        logic [4:0] cl;
        logic [4:0] f;
        logic [4:0] fin;
        logic [2:0] r;
        logic [7:0] ka;
        logic [7:0] kb;
        logic [7:0] kc;
        fi = dht_pkg::initial_of(k[0]);
        v2 = dht_pkg::vowel_two(k[1], k[2]);
        v1 = dht_pkg::vowel_one(k[1]);
        v = dht_pkg::NO_IDX;
        idx = dht_pkg::NO_IDX;
        cl = dht_pkg::NO_IDX;
        f = dht_pkg::NO_IDX;
        fin = 5'd0;
        r = 3'd1;
        ka = 8'h00;
        kb = 8'h00;
        kc = 8'h00;
        dec_code = code_reg[0];
        dec_used = 3'd1;
        if (k[0] == 8'h00)
        begin
            dec_code = code_reg[0];
        end
        else if (fi == dht_pkg::NO_IDX)
        begin
            v = dht_pkg::vowel_two(k[0], k[1]);
            if (v != dht_pkg::NO_IDX)
                dec_used = 3'd2;
            else
                v = dht_pkg::vowel_one(k[0]);
            dec_code = (v != dht_pkg::NO_IDX) ? dht_pkg::VOW_BASE + 16'(v) : code_reg[0];
        end
        else
        begin
            if (v2 != dht_pkg::NO_IDX)
            begin
                v = v2;
                r = 3'd3;
            end
            else if (v1 != dht_pkg::NO_IDX)
            begin
                v = v1;
                r = 3'd2;
            end
            if (v == dht_pkg::NO_IDX)
            begin
                // Consonant with no vowel: lone jamo or two-key cluster.
                idx = dht_pkg::single_one(k[0]);
                cl = dht_pkg::cluster_of(k[0], k[1]);
                if (!dht_pkg::is_vowel(k[2]) && cl != dht_pkg::NO_IDX)
                begin
                    idx = dht_pkg::jamo_of_cluster(cl);
                    dec_used = 3'd2;
                end
                dec_code = dht_pkg::CON_BASE + 16'(idx);
            end
            else
            begin
                ka = (r == 3'd3) ? k[3] : k[2];
                kb = (r == 3'd3) ? k[4] : k[3];
                kc = (r == 3'd3) ? k[5] : k[4];
                f = dht_pkg::final_one(ka);
                cl = dht_pkg::cluster_of(ka, kb);
                if (dht_pkg::is_vowel(kb))
                begin
                    fin = 5'd0;
                end
                else if (dht_pkg::is_vowel(kc))
                begin
                    if (f != dht_pkg::NO_IDX)
                    begin
                        fin = f;
                        r = r + 3'd1;
                    end
                end
                else if (cl != dht_pkg::NO_IDX)
                begin
                    fin = dht_pkg::final_of_cluster(cl);
                    r = r + 3'd2;
                end
                else if (f != dht_pkg::NO_IDX)
                begin
                    fin = f;
                    r = r + 3'd1;
                end
                dec_code = dht_pkg::SYL_BASE + 16'(fi) * dht_pkg::SYL_INIT_STEP
                         + 16'(v) * dht_pkg::SYL_VOW_STEP + 16'(fin);
                dec_used = r;
            end
        end
    end

    assign used_c   = (CW'(dec_used) > cnt_reg) ? cnt_reg : CW'(dec_used);
    assign need_dec = (cnt_reg >= CW'(dht_pkg::NEED)) || (flush_reg && cnt_reg != '0);
    assign dec_go   = need_dec && (!ovalid_reg || m_axis_tready);
    assign q_pop    = !need_dec && !flush_reg && q_valid && (cnt_reg < CW'(dht_pkg::NEED));

    always_comb
    begin
        cnt_next    = cnt_reg;
        flush_next  = flush_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        if (dec_go)
        begin
            cnt_next    = cnt_reg - used_c;
            ovalid_next = 1'b1;
            if (cnt_next == '0)
                flush_next = 1'b0;
        end
        else if (q_pop)
        begin
            cnt_next   = cnt_reg + 1'b1;
            flush_next = q_item.eot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            flush_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            flush_reg  <= flush_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_go)
        begin
            ocode_reg <= dec_code;
            olast_reg <= flush_reg && (cnt_reg == used_c);
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++)
            begin
                logic [SW-1:0] src;
                src = SW'(i) + SW'(used_c);
                if (src < SW'(LOOKAHEAD_DEPTH))
                begin
                    code_reg[i] <= code_reg[src[IW-1:0]];
                    key_reg[i]  <= key_reg[src[IW-1:0]];
                end
            end
        end
        else if (q_pop)
        begin
            code_reg[cnt_reg[IW-1:0]] <= q_item.code;
            key_reg[cnt_reg[IW-1:0]]  <= q_item.key;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ocode_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

### hdl/dubeolsik_to_hangul_transcoder_unit.sv
// Top level of the two-set keyboard to Hangul transcoder.
// Depends on dht_pkg, dht_front, dht_queue and dht_back.

// Each input item is one UTF-16 code unit typed in Latin letters on a two-set
// Korean layout; tlast on the input marks the last character of a text. The
// block holds a window of up to six characters and, once six are held, decides
// one unit at the window front: a composed syllable, a compatibility vowel or
// consonant jamo, or any non-letter passed through unchanged. An item with
// tlast flushes the window, producing up to six result items, the last of which
// carries tlast. The back end either takes a character into the window or
// makes a decision, never both at once, and a flush makes one decision per
// result. A four-entry queue between the input side and the decision logic
// lets either side stall alone, and while a result waits in the output
// register the window keeps taking items until it holds six.
module dubeolsik_to_hangul_transcoder_unit
#(
    parameter int LOOKAHEAD_DEPTH = dht_pkg::LOOKAHEAD_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_code
    output logic        m_axis_tlast    // out_last
);

    dht_pkg::q_wr_t q_wr;
    dht_pkg::item_t q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    // Input handshake and letter classification.
    dht_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    dht_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // Window, decision and output register.
    dht_back
    #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/tb_dubeolsik_to_hangul_transcoder_unit.sv
// Self-checking testbench for the two-set keyboard to Hangul transcoder.
// Depends on the block and its package; the key tables are modelled here.
module tb_dubeolsik_to_hangul_transcoder_unit;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } unit_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] char_code
    logic        s_axis_tlast;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] out_code
    logic        m_axis_tlast;   // out_last

    // Items waiting to be sent, and units the block should produce, oldest first.
    unit_t       send_q[$];
    unit_t       units_due[$];
    logic [15:0] win_chars[6];
    int          win_count;
    int          mismatches;
    int          send_gap;
    int          recv_gap;
    int          send_draw;
    int          recv_draw;
    bit          sending_done;

    dubeolsik_to_hangul_transcoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Key tables: each key lookup returns -1 for a key that has no entry.
    function automatic int lead_idx(int c);
        case (c)
            "r": return 0;   "R": return 1;   "s", "S": return 2;
            "e": return 3;   "E": return 4;   "f", "F": return 5;
            "a", "A": return 6;  "q": return 7;  "Q": return 8;
            "t": return 9;   "T": return 10;  "d", "D": return 11;
            "w": return 12;  "W": return 13;  "c", "C": return 14;
            "z", "Z": return 15; "x", "X": return 16; "v", "V": return 17;
            "g", "G": return 18;
            default: return -1;
        endcase
    endfunction

    function automatic int vowel_idx(int c);
        case (c)
            "k", "K": return 0;  "o": return 1;  "i", "I": return 2;
            "O": return 3;   "j", "J": return 4;  "p": return 5;
            "u", "U": return 6;  "P": return 7;  "h", "H": return 8;
            "y", "Y": return 12; "n", "N": return 13; "b", "B": return 17;
            "m", "M": return 18; "l", "L": return 20;
            default: return -1;
        endcase
    endfunction

    function automatic int fold(int c);
        return (c >= "A" && c <= "Z") ? c + 32 : c;
    endfunction

    function automatic int vowel_pair(int a, int b);
        int la;
        int lb;
        la = fold(a);
        lb = fold(b);
        if (la == "h") begin
            if (lb == "k") return 9;
            if (b == "o") return 10;
            if (lb == "l") return 11;
        end else if (la == "n") begin
            if (lb == "j") return 14;
            if (b == "p") return 15;
            if (lb == "l") return 16;
        end else if (la == "m" && lb == "l") begin
            return 19;
        end
        return -1;
    endfunction

    function automatic int tail_idx(int c);
        case (c)
            "r": return 1;   "R": return 2;   "s", "S": return 4;
            "e": return 7;   "f", "F": return 8;  "a", "A": return 16;
            "q": return 17;  "t": return 19;  "T": return 20;
            "d", "D": return 21; "w": return 22; "c", "C": return 23;
            "z", "Z": return 24; "x", "X": return 25; "v", "V": return 26;
            "g", "G": return 27;
            default: return -1;
        endcase
    endfunction

    function automatic int lone_con(int c);
        case (c)
            "r": return 0;   "R": return 1;   "s", "S": return 3;
            "e": return 6;   "E": return 7;   "f", "F": return 8;
            "a", "A": return 16; "q": return 17; "Q": return 18;
            "t": return 20;  "T": return 21;  "d", "D": return 22;
            "w": return 23;  "W": return 24;  "c", "C": return 25;
            "z", "Z": return 26; "x", "X": return 27; "v", "V": return 28;
            "g", "G": return 29;
            default: return -1;
        endcase
    endfunction

    function automatic int pair_con(int a, int b);
        int la;
        int lb;
        la = fold(a);
        lb = fold(b);
        if (a == "r" && b == "t") return 0;
        if (la == "s") begin
            if (b == "w") return 1;
            if (lb == "g") return 2;
        end
        if (la == "f") begin
            if (b == "r") return 3;
            if (lb == "a") return 4;
            if (b == "q") return 5;
            if (b == "t") return 6;
            if (lb == "x") return 7;
            if (lb == "v") return 8;
            if (lb == "g") return 9;
        end
        if (a == "q" && b == "t") return 10;
        return -1;
    endfunction

    function automatic int pair_tail(int x);
        int t[11] = '{3, 5, 6, 9, 10, 11, 12, 13, 14, 15, 18};
        return t[x];
    endfunction

    function automatic int pair_jamo(int x);
        int t[11] = '{2, 4, 5, 9, 10, 11, 12, 13, 14, 15, 19};
        return t[x];
    endfunction

    function automatic bit letter(int c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Positions past the held characters read as a non-letter.
    function automatic int peek(int i);
        return (i < win_count) ? int'(win_chars[i]) : 0;
    endfunction

    // Decides one unit at the window front and drops the keys it uses.
    function automatic logic [15:0] compose_front();
        int c0;
        int ld;
        int v;
        int x;
        int r;
        int fin;
        int used;
        int code;
        c0 = peek(0);
        used = 1;
        ld = lead_idx(c0);
        if (!letter(c0)) begin
            code = c0;
        end else if (ld < 0) begin
            v = vowel_pair(c0, peek(1));
            if (v >= 0) used = 2;
            else v = vowel_idx(c0);
            code = (v >= 0) ? 'h314F + v : c0;
        end else begin
            r = 1;
            fin = 0;
            v = vowel_pair(peek(1), peek(2));
            if (v >= 0) r = 3;
            else begin
                v = vowel_idx(peek(1));
                if (v >= 0) r = 2;
            end
            if (v < 0) begin
                x = pair_con(c0, peek(1));
                if (vowel_idx(peek(2)) < 0 && x >= 0) begin
                    code = 'h3131 + pair_jamo(x);
                    used = 2;
                end else begin
                    code = 'h3131 + lone_con(c0);
                end
            end else begin
                if (vowel_idx(peek(r + 1)) >= 0) begin
                    // The next key opens a new syllable, so no final.
                end else if (vowel_idx(peek(r + 2)) >= 0) begin
                    x = tail_idx(peek(r));
                    if (x >= 0) begin
                        fin = x;
                        r = r + 1;
                    end
                end else if (pair_con(peek(r), peek(r + 1)) >= 0) begin
                    fin = pair_tail(pair_con(peek(r), peek(r + 1)));
                    r = r + 2;
                end else if (tail_idx(peek(r)) >= 0) begin
                    fin = tail_idx(peek(r));
                    r = r + 1;
                end
                code = 'hAC00 + 588 * ld + 28 * v + fin;
                used = r;
            end
        end
        if (used > win_count) used = win_count;
        if (used == 0) used = 1;
        if (used >= win_count) begin
            win_count = 0;
        end else begin
            for (int i = 0; i < win_count - used; i++)
                win_chars[i] = win_chars[i + used];
            win_count = win_count - used;
        end
        return code[15:0];
    endfunction

    // Pushes one accepted character and queues every unit it lets out.
    function automatic void predict_units(logic [15:0] ch, logic eot);
        int n;
        unit_t u;
        n = 0;
        if (win_count < 6) begin
            win_chars[win_count] = ch;
            win_count++;
        end
        while (n < 6 && (win_count >= 6 || (eot && win_count > 0))) begin
            u.code = compose_front();
            u.last = eot && win_count == 0;
            units_due = {units_due, u};
            n++;
        end
    endfunction

    function automatic void queue_text(string s, bit eot);
        unit_t u;
        for (int i = 0; i < s.len(); i++) begin
            u.code = 16'(s[i]);
            u.last = eot && i == s.len() - 1;
            send_q = {send_q, u};
        end
    endfunction

    // Mostly letters from the key set, with some non-letters, wide code units
    // and text ends thrown in.
    function automatic unit_t rand_char();
        string keys;
        unit_t u;
        int p;
        keys = "rRseEfaqQtTdwWczxvgkoiOjpuPhynbmlKHNMLSFAGDIJUYB";
        p = $urandom_range(99);
        if (p < 80)
            u.code = 16'(keys[$urandom_range(keys.len() - 1)]);
        else if (p < 90)
            u.code = 16'($urandom_range(127));
        else
            u.code = 16'($urandom);
        u.last = ($urandom_range(19) == 0);
        return u;
    endfunction

    task automatic u_send(unit_t u);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= u.code;
        s_axis_tlast  <= u.last;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        unit_t u;
        rst_n = 1'b0;
        // Directed part: syllables with and without finals, two-key vowels,
        // clusters, shifted keys, a final left behind by a following vowel,
        // the doubled w refused as final, lone vowels and consonants, and the
        // field extremes.
        queue_text("dkssud", 0);
        queue_text("gksrmf", 0);
        queue_text("rhkdWk", 1);
        queue_text("fkfrh", 0);
        u.code = 16'hFFFF; u.last = 1'b0; send_q = {send_q, u};
        u.code = 16'h0000; u.last = 1'b1; send_q = {send_q, u};
        queue_text("tkW", 1);
        queue_text("kx", 1);
        queue_text("nplqtE", 1);
        repeat (273) send_q = {send_q, rand_char()};
        u.code = 16'h0041; u.last = 1'b1; send_q = {send_q, u};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #3000000;
        $display("tb_dubeolsik_to_hangul_transcoder_unit: done, errors");
        $finish;
    end

    // Driver: holds an item until it is taken, then waits a random gap; with
    // no gap the next item follows at once.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap      <= 0;
            sending_done  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_units(s_axis_tdata, s_axis_tlast);
                send_draw = ($urandom_range(3) == 0) ? 0 : $urandom_range(10);
                if (send_draw == 0 && send_q.size() > 0) begin
                    u_send(send_q.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_draw;
                end
            end else if (!s_axis_tvalid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (send_q.size() > 0) begin
                    u_send(send_q.pop_front());
                end else begin
                    sending_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: random back-pressure, and each accepted unit checked against
    // the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            mismatches    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (units_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected unit %h last %b", m_axis_tdata, m_axis_tlast);
                    mismatches <= mismatches + 1;
                end else if (units_due[0].code !== m_axis_tdata
                             || units_due[0].last !== m_axis_tlast) begin
                    if (mismatches < 10)
                        $display("unit mismatch: expected %h last %b, got %h last %b",
                                 units_due[0].code, units_due[0].last,
                                 m_axis_tdata, m_axis_tlast);
                    mismatches <= mismatches + 1;
                    void'(units_due.pop_front());
                end else begin
                    void'(units_due.pop_front());
                end
                recv_draw = ($urandom_range(3) == 0) ? 0 : $urandom_range(10);
                recv_gap <= recv_draw;
                m_axis_tready <= (recv_draw == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (rst_n);
        wait (sending_done && units_due.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && units_due.size() == 0)
            $display("tb_dubeolsik_to_hangul_transcoder_unit: done, clean");
        else
            $display("tb_dubeolsik_to_hangul_transcoder_unit: done, errors");
        $finish;
    end

endmodule
